FILE: src/gcpr_pkg.sv
`default_nettype none
package gcpr_pkg;

   // Register map
   typedef enum logic [0:0] {
      REG_GAMMA    = 1'b0,
      REG_CONTRAST = 1'b1
   } reg_index_type;

   localparam int Q31_FRAC = 31;
   localparam int EXP_STEPS = 31;

   // Integer square root, bit by bit
   function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
      logic [63:0] a;
      logic [63:0] r;
      logic [63:0] b;
      a = a_in;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (a >= r + b) begin
               a = a - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // log2 of n as Q.31 by repeated squaring of the mantissa
   function automatic logic [63:0] log2_q31(input logic [63:0] n);
      logic [63:0] e;
      logic [63:0] m;
      logic [63:0] frac;
      e = 64'd0;
      frac = 64'd0;
      for (int i = 0; i < 64; i++) begin
         if (n[i]) begin
            e = 64'(i);
         end
      end
      m = (n << 31) >> e;
      for (int k = 30; k >= 0; k--) begin
         m = (m * m) >> 31;
         if (m >= (64'd2 << 31)) begin
            m = m >> 1;
            frac = frac | (64'd1 << k);
         end
      end
      return (e << 31) | frac;
   endfunction

   // Factor 2^-(2^-(step+1)) in Q1.31 for exp step j (fraction bit 30-j)
   function automatic logic [31:0] exp_factor(input int step);
      logic [63:0] v;
      v = 64'd1 << 30;
      for (int i = 0; i <= step; i++) begin
         v = isqrt64(v << 31);
      end
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

FILE: src/gamma_contrast_pwl_ramp.sv
`default_nettype none
// Gamma ramp segment generator. Each transfer on req_ carries a segment index;
// the block evaluates contrast * x^gamma at both ends of the segment
// (x = i/SEGMENTS and (i+1)/SEGMENTS), clamps to [0,1], scales to 16 bits and
// returns the start level as segment_base and the rise as segment_delta.
// An index past the last segment is treated as the last segment. gamma and
// contrast are unsigned Q3.FRAC_BITS registers at byte addresses 0 and 4; a
// write is clamped to about 0.01..5. Throughput is one index per cycle; an
// index passes through the stages log lookup, exponent multiply, the 31-step
// exp2 multiplier chain (one multiply per stage), gain, rounding and output
// register. The whole pipeline halts while a result waits on rsp_ready.
module gamma_contrast_pwl_ramp #(
   parameter int SEGMENTS  = 128,
   parameter int FRAC_BITS = 13
) (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_valid,
   output logic              req_ready,
   input  wire  logic [$clog2(SEGMENTS)-1:0] req_segment_index,
   output logic              rsp_valid,
   input  wire  logic        rsp_ready,
   output logic [15:0]       rsp_segment_base,
   output logic [15:0]       rsp_segment_delta,
   input  wire  logic        psel,
   input  wire  logic        penable,
   input  wire  logic        pwrite,
   input  wire  logic [2:0]  paddr,
   input  wire  logic [31:0] pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import gcpr_pkg::*;

   localparam int NW   = $clog2(SEGMENTS + 1);
   localparam int LNW  = Q31_FRAC + NW;
   localparam int TW   = LNW + 16;
   localparam int IW   = TW - Q31_FRAC;
   localparam int GW   = 32;
   localparam logic [GW-1:0] GAIN_ONE = GW'(64'd1 << FRAC_BITS);
   localparam logic [GW-1:0] GAIN_LO  = GW'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [GW-1:0] GAIN_HI  = GW'(64'd5 << FRAC_BITS);
   localparam logic [63:0]   LOG_TOP  = log2_q31(64'(SEGMENTS));

   // Configuration registers
   logic [15:0] gamma_ff, contrast_ff;
   logic [15:0] cfg_val;
   logic        cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   // Clamp the written value to the legal gain range
   always_comb begin
      priority if (GW'(pwdata[15:0]) < GAIN_LO) begin
         cfg_val = GAIN_LO[15:0];
      end else if (GW'(pwdata[15:0]) > GAIN_HI) begin
         cfg_val = GAIN_HI[15:0];
      end else begin
         cfg_val = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff    <= GAIN_ONE[15:0];
         contrast_ff <= GAIN_ONE[15:0];
      end else if (cfg_wr) begin
         unique case (reg_index_type'(paddr[2]))
            REG_GAMMA:    gamma_ff    <= cfg_val;
            REG_CONTRAST: contrast_ff <= cfg_val;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[2]))
         REG_GAMMA:    prdata = {16'd0, gamma_ff};
         REG_CONTRAST: prdata = {16'd0, contrast_ff};
         default:      prdata = 32'd0;
      endcase
   end

   // Log table: log2(SEGMENTS) - log2(n), built at elaboration
   logic [LNW-1:0] ln_rom [SEGMENTS+1];
   for (genvar g = 0; g <= SEGMENTS; g++) begin : g_ln
      if (g == 0) begin : g_zero
         assign ln_rom[g] = '0;
      end else begin : g_val
         assign ln_rom[g] = LNW'(LOG_TOP - log2_q31(64'(g)));
      end
   end

   // Pipeline advance: the whole pipe moves unless the output is held
   logic adv;
   logic o_vld_ff;
   assign adv       = !o_vld_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = o_vld_ff;

   // Saturate the index and form both abscissas
   logic [NW-1:0] n_lo, n_hi, idx_w;
   always_comb begin
      idx_w = NW'(req_segment_index);
      if (32'(req_segment_index) >= 32'(SEGMENTS)) begin
         n_lo = NW'(SEGMENTS - 1);
      end else begin
         n_lo = idx_w;
      end
      n_hi = n_lo + NW'(1);
   end

   // Stage A: log lookup
   logic           a_vld_ff, a_zero_ff;
   logic [LNW-1:0] a_ln_ff [2];
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         a_ln_ff[0] <= ln_rom[n_lo];
         a_ln_ff[1] <= ln_rom[n_hi];
         a_zero_ff  <= (n_lo == '0);
      end
   end

   // Stage B: exponent t = ln * gamma
   logic          b_vld_ff, b_zero_ff;
   logic [30:0]   b_tf_ff [2];
   logic [IW-1:0] b_ti_ff [2];
   logic [TW-1:0] t_full [2];
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         t_full[l] = (TW'(a_ln_ff[l]) * TW'(gamma_ff)) >> FRAC_BITS;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         b_zero_ff <= a_zero_ff;
         for (int l = 0; l < 2; l++) begin
            b_tf_ff[l] <= t_full[l][30:0];
            b_ti_ff[l] <= t_full[l][TW-1:31];
         end
      end
   end

   // Exp2 chain: one fractional bit of t per stage
   logic          e_vld_ff  [EXP_STEPS];
   logic          e_zero_ff [EXP_STEPS];
   logic [31:0]   e_p_ff    [EXP_STEPS][2];
   logic [30:0]   e_tf_ff   [EXP_STEPS][2];
   logic [IW-1:0] e_ti_ff   [EXP_STEPS][2];

   for (genvar j = 0; j < EXP_STEPS; j++) begin : g_exp
      localparam logic [31:0] FACTOR = exp_factor(j);
      logic          vld_in, zero_in;
      logic [31:0]   p_in  [2];
      logic [30:0]   tf_in [2];
      logic [IW-1:0] ti_in [2];
      logic [63:0]   prod  [2];

      if (j == 0) begin : g_first
         assign vld_in   = b_vld_ff;
         assign zero_in  = b_zero_ff;
         assign p_in[0]  = 32'd1 << Q31_FRAC;
         assign p_in[1]  = 32'd1 << Q31_FRAC;
         assign tf_in[0] = b_tf_ff[0];
         assign tf_in[1] = b_tf_ff[1];
         assign ti_in[0] = b_ti_ff[0];
         assign ti_in[1] = b_ti_ff[1];
      end else begin : g_next
         assign vld_in   = e_vld_ff[j-1];
         assign zero_in  = e_zero_ff[j-1];
         assign p_in[0]  = e_p_ff[j-1][0];
         assign p_in[1]  = e_p_ff[j-1][1];
         assign tf_in[0] = e_tf_ff[j-1][0];
         assign tf_in[1] = e_tf_ff[j-1][1];
         assign ti_in[0] = e_ti_ff[j-1][0];
         assign ti_in[1] = e_ti_ff[j-1][1];
      end

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            prod[l] = 64'(p_in[l]) * 64'(FACTOR);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            e_vld_ff[j] <= 1'b0;
         end else if (adv) begin
            e_vld_ff[j] <= vld_in;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            e_zero_ff[j] <= zero_in;
            for (int l = 0; l < 2; l++) begin
               e_tf_ff[j][l] <= tf_in[l];
               e_ti_ff[j][l] <= ti_in[l];
               if (tf_in[l][30-j]) begin
                  e_p_ff[j][l] <= prod[l][62:31];
               end else begin
                  e_p_ff[j][l] <= p_in[l];
               end
            end
         end
      end
   end

   // Stage C: integer shift and contrast gain
   logic        c_vld_ff, c_zero_ff;
   logic [47:0] c_q_ff [2];
   logic [31:0] p_sh [2];
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         p_sh[l] = e_p_ff[EXP_STEPS-1][l] >> e_ti_ff[EXP_STEPS-1][l];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= e_vld_ff[EXP_STEPS-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c_zero_ff <= e_zero_ff[EXP_STEPS-1];
         for (int l = 0; l < 2; l++) begin
            c_q_ff[l] <= (48'(contrast_ff) * 48'(p_sh[l])) >> FRAC_BITS;
         end
      end
   end

   // Stage D: clamp to one and round to 16 bits
   logic        d_vld_ff;
   logic [15:0] d_lvl_ff [2];
   logic [31:0] r_cl [2];
   logic [47:0] lvl_w [2];
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (c_q_ff[l] > (48'd1 << Q31_FRAC)) begin
            r_cl[l] = 32'd1 << Q31_FRAC;
         end else begin
            r_cl[l] = c_q_ff[l][31:0];
         end
         lvl_w[l] = (48'(r_cl[l]) << 16) - 48'(r_cl[l]) + (48'd1 << 30);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= c_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d_lvl_ff[0] <= c_zero_ff ? 16'd0 : lvl_w[0][46:31];
         d_lvl_ff[1] <= lvl_w[1][46:31];
      end
   end

   // Output register: base and non-negative rise
   logic [15:0] o_base_ff, o_delta_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (adv) begin
         o_vld_ff <= d_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         o_base_ff  <= d_lvl_ff[0];
         o_delta_ff <= (d_lvl_ff[1] >= d_lvl_ff[0]) ? d_lvl_ff[1] - d_lvl_ff[0] : 16'd0;
      end
   end

   assign rsp_segment_base  = o_base_ff;
   assign rsp_segment_delta = o_delta_ff;

endmodule
`default_nettype wire
